// File: rtl/ean13_pkg.sv
// shared types, constants and code tables of the ean-13 width decoder
`default_nettype none
package ean13_pkg;

  // field widths
  localparam int IN_W           = 16;
  localparam int WIDTH_BITS_DEF = 16;
  localparam int TOTAL_W        = 22;
  localparam int LIMIT_W        = 24;
  localparam int DIGITS_W       = 52;
  localparam int CONF_W         = 16;
  localparam int STATUS_W       = 3;

  // run geometry
  localparam int KEEP_WIDTHS = 59;
  localparam int CNT_W       = $clog2(KEEP_WIDTHS + 1);
  localparam int MEM_AW      = CNT_W + 1;
  localparam int LEFT_DIGITS = 6;
  localparam int GUARD_L_END = 3;
  localparam int GUARD_M_LO  = 27;
  localparam int GUARD_M_HI  = 31;
  localparam int GUARD_R_LO  = 56;

  // arithmetic
  localparam int NORM_SCALE = 95 * 256;
  localparam int N_W        = 15;
  localparam int SQ_W       = 30;
  localparam int CAND_W     = SQ_W + 2;
  localparam int GE_W       = SQ_W + 4;
  localparam int E_W        = 36;
  localparam int LIMIT_RESET = 327680;
  localparam int CONF_SPAN  = 20 * 65536;
  localparam int X_W        = 19;
  localparam int RECIP5     = 838861;
  localparam int RECIP_W    = 20;
  localparam int RECIP_SH   = 22;
  localparam int CPROD_W    = X_W + RECIP_W;
  localparam int Q_W        = CPROD_W - RECIP_SH;

  localparam int JOBQ_DEPTH = 2;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_SHORT  = 3'd1,
    STAT_GUARD  = 3'd2,
    STAT_PARITY = 3'd3,
    STAT_CHECK  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_DIVGO, ST_DIVWAIT, ST_SQ, ST_NEXT,
    ST_CSUM, ST_CCMP, ST_DIG, ST_END, ST_FIN
  } back_state_t;

  typedef struct packed {
    logic [IN_W-1:0] bar_width;
    logic            last_width;
  } in_t;

  typedef struct packed {
    logic                decode_ok;
    logic [STATUS_W-1:0] status;
    logic [DIGITS_W-1:0] digits_packed;
    logic [CONF_W-1:0]   confidence;
  } out_t;

  typedef struct packed {
    logic               bank;
    logic               full;
    logic [TOTAL_W-1:0] total;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } rd_req_t;

  // module count of element col of the l pattern for digit d
  function automatic logic [2:0] pat_modules(input logic [3:0] d, input logic [1:0] col);
    logic [11:0] row;
    unique case (d)
      4'd0:    row = {3'd3, 3'd2, 3'd1, 3'd1};
      4'd1:    row = {3'd2, 3'd2, 3'd2, 3'd1};
      4'd2:    row = {3'd2, 3'd1, 3'd2, 3'd2};
      4'd3:    row = {3'd1, 3'd4, 3'd1, 3'd1};
      4'd4:    row = {3'd1, 3'd1, 3'd3, 3'd2};
      4'd5:    row = {3'd1, 3'd2, 3'd3, 3'd1};
      4'd6:    row = {3'd1, 3'd1, 3'd1, 3'd4};
      4'd7:    row = {3'd1, 3'd3, 3'd1, 3'd2};
      4'd8:    row = {3'd1, 3'd2, 3'd1, 3'd3};
      4'd9:    row = {3'd3, 3'd1, 3'd1, 3'd2};
      default: row = {3'd1, 3'd1, 3'd1, 3'd1};
    endcase
    return row[(3 - col) * 3 +: 3];
  endfunction

  // first digit from left parity bits, msb set when a pattern matches
  function automatic logic [4:0] parity_lead(input logic [5:0] par);
    logic [5:0] tbl [10];
    logic [4:0] res;
    tbl = '{6'h00, 6'h34, 6'h2C, 6'h1C, 6'h32, 6'h26, 6'h0E, 6'h2A, 6'h1A, 6'h16};
    res = '0;
    for (int k = 9; k >= 0; k--) begin
      if (tbl[k] == par) res = {1'b1, 4'(k)};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ean13_front.sv
// front end: width intake, two-bank width store and run bookkeeping
`default_nettype none
module ean13_front import ean13_pkg::*; #(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      push,
  output job_t      push_job,
  input  wire logic job_done,
  input  wire rd_req_t rd_req,
  output logic [((WIDTH_BITS < IN_W) ? WIDTH_BITS : IN_W)-1:0] rd_data
);

  localparam int KW = (WIDTH_BITS < IN_W) ? WIDTH_BITS : IN_W;

  logic [KW-1:0]      mem [2**MEM_AW];
  logic [KW-1:0]      rd_data_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TOTAL_W-1:0] total_r;
  logic               bank_r;
  logic [1:0]         outst_r;
  logic               accept, keep;
  logic [KW-1:0]      w;

  assign in_ready = (outst_r < 2'(JOBQ_DEPTH));
  assign accept   = in_valid && in_ready;
  assign w        = in_data.bar_width[KW-1:0];
  assign keep     = (cnt_r < CNT_W'(KEEP_WIDTHS));
  assign push     = accept && in_data.last_width;
  assign rd_data  = rd_data_r;

  always_comb begin
    push_job.bank  = bank_r;
    push_job.full  = (cnt_r == CNT_W'(KEEP_WIDTHS)) || (cnt_r == CNT_W'(KEEP_WIDTHS - 1));
    push_job.total = total_r + (keep ? TOTAL_W'(w) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
      bank_r  <= 1'b0;
      outst_r <= '0;
    end else begin
      if (accept) begin
        if (in_data.last_width) begin
          cnt_r   <= '0;
          total_r <= '0;
          bank_r  <= !bank_r;
        end else if (keep) begin
          cnt_r   <= cnt_r + 1'b1;
          total_r <= total_r + TOTAL_W'(w);
        end
      end
      outst_r <= outst_r + {1'b0, push} - {1'b0, job_done};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) mem[{bank_r, cnt_r}] <= w;
    if (rd_req.en) rd_data_r <= mem[rd_req.addr];
  end

endmodule
`default_nettype wire

// File: rtl/ean13_jobq.sv
// small fifo of finished runs waiting for the decode back end
`default_nettype none
module ean13_jobq import ean13_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head
);

  localparam int PTR_W = $clog2(JOBQ_DEPTH);

  job_t             q_r [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

// File: rtl/ean13_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module ean13_div import ean13_pkg::*; #(
  parameter int DW = 31,
  parameter int VW = TOTAL_W,
  parameter int QW = N_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [QW-1:0]      quot
);

  localparam int CW = $clog2(QW + 1);

  logic [VW-1:0] rem_r, div_r;
  logic [QW-1:0] low_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [VW:0]   trial;
  logic          qbit;

  assign trial = {rem_r, low_r[QW-1]};
  assign qbit  = (trial >= {1'b0, div_r});
  assign done  = busy_r && (cnt_r == '0);
  assign quot  = low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= VW'(dividend[DW-1:QW]);
      low_r <= dividend[QW-1:0];
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= qbit ? VW'(trial - {1'b0, div_r}) : VW'(trial);
      low_r <= {low_r[QW-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

// File: rtl/ean13_back.sv
// back end: normalization, guard and digit matching, result register
`default_nettype none
module ean13_back import ean13_pkg::*; #(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output rd_req_t   rd_req,
  input  wire logic [((WIDTH_BITS < IN_W) ? WIDTH_BITS : IN_W)-1:0] rd_data,
  input  wire logic [LIMIT_W-1:0] limit,
  output logic      job_done,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int KW = (WIDTH_BITS < IN_W) ? WIDTH_BITS : IN_W;
  localparam int PW = KW + N_W;

  back_state_t state_r, state_nxt;

  logic               bank_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CNT_W-1:0]   idx_r;
  logic [1:0]         slot_r, m_r;
  logic [3:0]         pos_r;
  logic [PW-1:0]      prod_r;
  logic [N_W-1:0]     n_r;
  logic [SQ_W-1:0]    sqe_r [4][4];
  logic [3:0]         d_r, bd_r, first_r;
  logic               g_r, bg_r;
  logic [CAND_W-1:0]  cand_r, best_r;
  logic [GE_W-1:0]    ge_r;
  logic [E_W-1:0]     e_r;
  logic [3:0]         acc_r;
  logic [5:0]         par_r;
  logic [47:0]        digs_r;
  status_t            status_r;
  logic               fail_r, big_r;
  logic [CPROD_W-1:0] cprod_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic               div_start, div_done, load, guard, right, last_cand;
  logic [N_W-1:0]     div_quot;
  logic [16:0]        diff, absd;
  logic [SQ_W-1:0]    sq;
  logic [CAND_W-1:0]  cand_sum;
  logic [E_W-1:0]     e_tot;
  logic [4:0]         fd;
  logic [4:0]         chk_s;
  logic [5:0]         acc_t;
  logic [4:0]         acc_add;
  logic [Q_W-1:0]     q;
  logic [CONF_W-1:0]  conf;

  ean13_div #(.DW(PW), .VW(TOTAL_W), .QW(N_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod_r),
    .divisor(total_r), .done(div_done), .quot(div_quot)
  );

  assign guard = (idx_r < CNT_W'(GUARD_L_END)) || (idx_r >= CNT_W'(GUARD_R_LO)) ||
                 ((idx_r >= CNT_W'(GUARD_M_LO)) && (idx_r <= CNT_W'(GUARD_M_HI)));
  assign right = (pos_r >= 4'(LEFT_DIGITS));
  assign last_cand = (d_r == 4'd9) && (right || g_r);

  // squared error of the current width against m_r+1 modules
  assign diff = {2'b00, n_r} - {6'd0, {1'b0, m_r} + 3'd1, 8'd0};
  assign absd = diff[16] ? (~diff + 17'd1) : diff;
  assign sq   = SQ_W'(absd[15:0] * absd[15:0]);

  always_comb begin
    logic [1:0] col;
    logic [2:0] mods;
    cand_sum = '0;
    for (int i = 0; i < 4; i++) begin
      col  = g_r ? 2'(3 - i) : 2'(i);
      mods = pat_modules(d_r, col) - 3'd1;
      cand_sum = cand_sum + CAND_W'(sqe_r[i][mods[1:0]]);
    end
  end

  assign e_tot   = E_W'(ge_r) + e_r;
  assign fd      = parity_lead(par_r);
  assign chk_s   = {1'b0, acc_r} + {1'b0, fd[3:0]};
  assign acc_add = pos_r[0] ? {1'b0, bd_r} : ({1'b0, bd_r} + {bd_r, 1'b0});
  assign acc_t   = {2'b00, acc_r} + {1'b0, acc_add};
  assign q       = cprod_r[RECIP_SH +: Q_W];

  always_comb begin
    if (big_r)           conf = '0;
    else if (q == '0)    conf = '1;
    else                 conf = CONF_W'(17'h10000 - 17'(q));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    rd_req.en = 1'b0;
    rd_req.addr = {bank_r, idx_r};
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          state_nxt = (!job.full || job.total == '0) ? ST_FIN : ST_READ;
        end
      end
      ST_READ: begin
        rd_req.en = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL:   state_nxt = ST_DIVGO;
      ST_DIVGO: begin
        div_start = 1'b1;
        state_nxt = ST_DIVWAIT;
      end
      ST_DIVWAIT: if (div_done) state_nxt = ST_SQ;
      ST_SQ: begin
        if (guard)               state_nxt = ST_NEXT;
        else if (m_r == 2'd3)    state_nxt = (slot_r == 2'd3) ? ST_CSUM : ST_NEXT;
      end
      ST_NEXT: state_nxt = (idx_r == CNT_W'(KEEP_WIDTHS - 1)) ? ST_END : ST_READ;
      ST_CSUM: state_nxt = ST_CCMP;
      ST_CCMP: state_nxt = last_cand ? ST_DIG : ST_CSUM;
      ST_DIG:  state_nxt = ST_NEXT;
      ST_END:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign job_done  = load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        bank_r   <= job.bank;
        total_r  <= job.total;
        idx_r    <= '0;
        slot_r   <= '0;
        pos_r    <= '0;
        ge_r     <= '0;
        e_r      <= '0;
        acc_r    <= '0;
        par_r    <= '0;
        digs_r   <= '0;
        first_r  <= '0;
        fail_r   <= 1'b1;
        status_r <= job.full ? STAT_GUARD : STAT_SHORT;
      end
      ST_MUL:     prod_r <= PW'(rd_data) * PW'(NORM_SCALE);
      ST_DIVWAIT: begin
        n_r <= div_quot;
        m_r <= '0;
      end
      ST_SQ: begin
        if (guard) begin
          ge_r <= ge_r + GE_W'(sq);
        end else begin
          sqe_r[slot_r][m_r] <= sq;
          m_r <= m_r + 1'b1;
          if (m_r == 2'd3) begin
            slot_r <= slot_r + 1'b1;
            d_r    <= '0;
            g_r    <= 1'b0;
          end
        end
      end
      ST_NEXT: idx_r <= idx_r + 1'b1;
      ST_CSUM: cand_r <= cand_sum;
      ST_CCMP: begin
        // strict compare keeps the earlier digit, l before g
        if ((d_r == '0 && !g_r) || cand_r < best_r) begin
          best_r <= cand_r;
          bd_r   <= d_r;
          bg_r   <= g_r;
        end
        if (!right && !g_r) begin
          g_r <= 1'b1;
        end else begin
          g_r <= 1'b0;
          d_r <= d_r + 1'b1;
        end
      end
      ST_DIG: begin
        e_r    <= e_r + E_W'(best_r);
        digs_r <= {digs_r[43:0], bd_r};
        if (!right && bg_r) par_r[pos_r[2:0]] <= 1'b1;
        if (acc_t >= 6'd30)      acc_r <= 4'(acc_t - 6'd30);
        else if (acc_t >= 6'd20) acc_r <= 4'(acc_t - 6'd20);
        else if (acc_t >= 6'd10) acc_r <= 4'(acc_t - 6'd10);
        else                     acc_r <= acc_t[3:0];
        pos_r <= pos_r + 1'b1;
      end
      ST_END: begin
        first_r <= fd[3:0];
        big_r   <= (e_tot >= E_W'(CONF_SPAN));
        cprod_r <= CPROD_W'(e_tot[X_W+1:2]) * CPROD_W'(RECIP5);
        priority if (ge_r > GE_W'(limit)) begin
          status_r <= STAT_GUARD;
          fail_r   <= 1'b1;
        end else if (!fd[4]) begin
          status_r <= STAT_PARITY;
          fail_r   <= 1'b1;
        end else if (chk_s != 5'd0 && chk_s != 5'd10) begin
          status_r <= STAT_CHECK;
          fail_r   <= 1'b1;
        end else begin
          status_r <= STAT_OK;
          fail_r   <= 1'b0;
        end
      end
      default: ;
    endcase
    if (load) begin
      out_data_r.decode_ok     <= !fail_r;
      out_data_r.status        <= status_r;
      out_data_r.digits_packed <= fail_r ? '0 : {first_r, digs_r};
      out_data_r.confidence    <= fail_r ? '0 : conf;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ean13_width_decoder_unit.sv
// top level of the ean-13 width decoder
`default_nettype none
// Bar and space widths stream in at one beat per cycle while in_ready is high
// and land in one of two store banks; a beat with last_width set closes the
// run and queues it for decode, so the next run can stream into the other
// bank while the first is decoded. Only the first 59 widths of a run are kept.
// Decode walks the 59 kept widths one by one: a store read, a 24320x multiply
// and a restoring divider (one quotient bit per cycle) give the normalized
// width, then one squarer builds the error against 1 module (guards) or 1 to
// 4 modules (digit widths). Every fourth digit width is matched against the
// l and g patterns (left half) or the l pattern (right half), each candidate
// summed and then compared. A short run or a zero total skips the walk.
// With both banks waiting, in_ready drops until a result has been handed to
// the output register. The user must write the guard error limit through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module ean13_width_decoder_unit import ean13_pkg::*; #(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_t                    out_data,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int KW = (WIDTH_BITS < IN_W) ? WIDTH_BITS : IN_W;

  logic [LIMIT_W-1:0] limit_r;
  logic               push, pop, head_valid, job_done;
  job_t               push_job, head;
  rd_req_t            rd_req;
  logic [KW-1:0]      rd_data;

  // guard error limit, q.16
  always_ff @(posedge clk) begin
    if (!rst_n)      limit_r <= LIMIT_W'(LIMIT_RESET);
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  // intake and width store
  ean13_front #(.WIDTH_BITS(WIDTH_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .push(push), .push_job(push_job), .job_done(job_done),
    .rd_req(rd_req), .rd_data(rd_data)
  );

  // runs waiting for decode
  ean13_jobq u_jobq (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
    .head_valid(head_valid), .head(head)
  );

  // decode and result register
  ean13_back #(.WIDTH_BITS(WIDTH_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(head_valid), .job(head), .job_pop(pop),
    .rd_req(rd_req), .rd_data(rd_data), .limit(limit_r), .job_done(job_done),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire
